### rtl/core/assert_macros.svh
// Assertion macros shared by the compensation block.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a condition on every clock edge outside reset.
`define BPC_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
// Checks that a condition holds in the cycle after its trigger.
`define BPC_ASSERT_NEXT(name, trig, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error("assertion failed");
`else
`define BPC_ASSERT(name, prop)
`define BPC_ASSERT_NEXT(name, trig, prop)
`endif
`endif

### rtl/core/bpc_pkg.sv
// Types, constants and helper functions of the pressure compensation block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    // Input and result beats.
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pressure_pa;
        logic signed [27:0] temperature_tenths;
        logic [1:0]         error_status;
    } t_out;

    // Calibration set as seen by the datapath.
    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_cal;

    // Entry of the queue between front and back.
    typedef struct packed {
        logic [31:0] x1s;
        logic [23:0] up;
    } t_fq;

    // Register indexes.
    localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [2:0] CFG_B1_B2   = 3'd3;
    localparam logic [2:0] CFG_MC_MD   = 3'd4;
    localparam logic [2:0] CFG_OSS     = 3'd5;

    // Status codes.
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_TEMP_DIV0 = 2'd1;
    localparam logic [1:0] ERR_PRES_DIV0 = 2'd2;

    // Arithmetic constants of the compensation.
    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] K_3038      = 32'd3038;
    localparam logic [31:0] K_M7357     = 32'hFFFF_E343;
    localparam logic [31:0] K_3791      = 32'd3791;
    localparam logic [31:0] K_50000     = 32'd50000;
    localparam logic [31:0] K_32768     = 32'd32768;
    localparam logic [31:0] K_HALF      = 32'h8000_0000;

    localparam int QDEPTH = 4;

    // Arithmetic right shift of a 32-bit word.
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        asr = 32'($signed(v) >>> n);
    endfunction

    // Sign extension of a 16-bit coefficient.
    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

### rtl/core/bpc_div.sv
// Pipelined unsigned 32 by 32 divider, one quotient bit per stage.
// Depends on nothing; a side word travels alongside each beat.
`timescale 1ns / 1ps
`default_nettype none
module bpc_div #(
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_num,
    input  wire logic [31:0]   i_den,
    input  wire logic [PW-1:0] i_side,
    output logic               o_valid,
    output logic [31:0]        o_quo,
    output logic [PW-1:0]      o_side
);
    localparam int NS = 32;

    logic          r_vld  [0:NS];
    logic [31:0]   r_rem  [0:NS];
    logic [31:0]   r_num  [0:NS];
    logic [31:0]   r_den  [0:NS];
    logic [PW-1:0] r_side [0:NS];

    // Entry stage loads the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= '0;
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    // Each stage takes one trial subtraction.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [32:0] rem_sh;
        logic [32:0] diff;
        logic        ge;
        assign rem_sh = {r_rem[k], r_num[k][31]};
        assign diff   = rem_sh - {1'b0, r_den[k]};
        assign ge     = !diff[32];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= ge ? diff[31:0] : rem_sh[31:0];
            r_num[k+1]  <= {r_num[k][30:0], ge};
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[NS];
    assign o_quo   = r_num[NS];
    assign o_side  = r_side[NS];
endmodule
`default_nettype wire

### rtl/core/bpc_fifo.sv
// Short queue between the front and back parts.
// Depends on bpc_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module bpc_fifo
    import bpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_fq  i_data,
    output logic      o_valid,
    output t_fq       o_data,
    output logic      o_almost_full
);
    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_fq           r_mem [0:QDEPTH-1];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          r_valid;
    logic          pop;

    // The back part never stalls, so an entry leaves as soon as one is held.
    assign pop = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (pop) begin
            o_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= pop;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_almost_full = (r_count >= CW'(QDEPTH - 1));
endmodule
`default_nettype wire

### rtl/core/bpc_front.sv
// Front part: takes the raw beat, aligns the pressure and forms X1.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpc_front
    import bpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_in  i_item,
    input  wire t_cal i_cal,
    output logic      o_push,
    output t_fq       o_data
);
    logic        r_v0, r_v1;
    t_in         r_item;
    logic [31:0] r_prod;
    logic [23:0] r_up;
    logic [31:0] prod;
    logic [23:0] up;

    // Temperature product and pressure alignment.
    assign prod = ({16'd0, r_item.raw_temperature} - {16'd0, i_cal.ac6})
                  * {16'd0, i_cal.ac5};

    always_comb begin
        unique case (i_cal.oss)
            2'd0:    up = r_item.raw_pressure >> 8;
            2'd1:    up = r_item.raw_pressure >> 7;
            2'd2:    up = r_item.raw_pressure >> 6;
            default: up = r_item.raw_pressure >> 5;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            o_push <= 1'b0;
        end else begin
            r_v0   <= i_accept;
            r_v1   <= r_v0;
            o_push <= r_v1;
        end
        r_item <= i_item;
        r_prod <= prod;
        r_up   <= up;
        // Division by 2^15 that truncates toward zero.
        o_data.x1s <= r_prod[31] ? asr(r_prod + 32'd32767, 15) : asr(r_prod, 15);
        o_data.up  <= r_up;
    end
endmodule
`default_nettype wire

### rtl/core/bpc_back.sv
// Back part: temperature division, pressure polynomial and final correction.
// Depends on bpc_pkg and bpc_div.
`timescale 1ns / 1ps
`default_nettype none
module bpc_back
    import bpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_fq  i_data,
    input  wire t_cal i_cal,
    output logic      o_strobe,
    output t_out      o_result
);
    // Temperature division: X2 = MC*2048 / (X1 + MD), signed.
    localparam int PW1 = 32 + 24 + 2;
    logic [31:0]    den_t, num_t, mag_n, mag_d;
    logic           tz, neg_t;
    logic           d1_vld;
    logic [31:0]    d1_quo;
    logic [PW1-1:0] d1_side;
    logic [31:0]    d1_x1s;
    logic [23:0]    d1_up;
    logic           d1_tz, d1_neg;

    assign den_t = i_data.x1s + sx16(i_cal.md);
    assign num_t = {{5{i_cal.mc[15]}}, i_cal.mc, 11'd0};
    assign tz    = (den_t == '0);
    assign neg_t = num_t[31] ^ den_t[31];
    assign mag_n = num_t[31] ? -num_t : num_t;
    assign mag_d = tz ? 32'd1 : (den_t[31] ? -den_t : den_t);

    bpc_div #(.PW(PW1)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (mag_n),
        .i_den   (mag_d),
        .i_side  ({i_data.x1s, i_data.up, tz, neg_t}),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );
    assign {d1_x1s, d1_up, d1_tz, d1_neg} = d1_side;

    // Stage 1: B5, temperature and B6.
    logic        r1_v, r1_tz;
    logic [31:0] r1_b6;
    logic [27:0] r1_temp;
    logic [23:0] r1_up;
    logic [31:0] b5, b5r;
    assign b5  = d1_x1s + (d1_neg ? -d1_quo : d1_quo);
    assign b5r = asr(b5 + 32'd8, 4);

    // Stage 2: products of B6.
    logic        r2_v, r2_tz;
    logic [31:0] r2_sqp, r2_ac2p, r2_ac3p;
    logic [27:0] r2_temp;
    logic [23:0] r2_up;

    // Stage 3: scaled terms.
    logic        r3_v, r3_tz;
    logic [31:0] r3_sq, r3_x2a, r3_x1c;
    logic [27:0] r3_temp;
    logic [23:0] r3_up;

    // Stage 4: products with B1 and B2.
    logic        r4_v, r4_tz;
    logic [31:0] r4_b2sq, r4_b1sq, r4_x2a, r4_x1c;
    logic [27:0] r4_temp;
    logic [23:0] r4_up;

    // Stage 5: B3 and the B4 term.
    logic        r5_v, r5_tz;
    logic [31:0] r5_b3, r5_x3b;
    logic [27:0] r5_temp;
    logic [23:0] r5_up;
    logic [31:0] x3, t3, x3b;
    assign x3  = asr(r4_b2sq, 11) + r4_x2a;
    assign t3  = ((sx16(i_cal.ac1) * 32'd4 + x3) << i_cal.oss) + 32'd2;
    assign x3b = asr(r4_x1c + asr(r4_b1sq, 16) + 32'd2, 2);

    // Stage 6: B4 and UP - B3.
    logic        r6_v, r6_tz;
    logic [31:0] r6_b4, r6_b7p;
    logic [27:0] r6_temp;
    logic [31:0] b4;
    assign b4 = ({16'd0, i_cal.ac4} * (r5_x3b + K_32768)) >> 15;

    // Stage 7: B7.
    logic        r7_v, r7_tz;
    logic [31:0] r7_b4, r7_b7;
    logic [27:0] r7_temp;

    // Pressure division: B7 scaled by two before or after.
    localparam int PW2 = 28 + 3;
    logic           big, bz;
    logic           d2_vld;
    logic [31:0]    d2_quo;
    logic [PW2-1:0] d2_side;
    logic [27:0]    d2_temp;
    logic           d2_tz, d2_bz, d2_big;
    assign big = (r7_b7 >= K_HALF);
    assign bz  = (r7_b4 == '0);

    bpc_div #(.PW(PW2)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_v),
        .i_num   (big ? r7_b7 : {r7_b7[30:0], 1'b0}),
        .i_den   (bz ? 32'd1 : r7_b4),
        .i_side  ({r7_temp, r7_tz, bz, big}),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );
    assign {d2_temp, d2_tz, d2_bz, d2_big} = d2_side;

    // Stage 8: correction products.
    logic        r8_v, r8_tz, r8_bz;
    logic [31:0] r8_p, r8_x1m, r8_x2m;
    logic [27:0] r8_temp;
    logic [31:0] p0, ps;
    assign p0 = d2_big ? {d2_quo[30:0], 1'b0} : d2_quo;
    assign ps = asr(p0, 8);

    // Stage 9: scaled correction terms.
    logic        r9_v, r9_tz, r9_bz;
    logic [31:0] r9_p, r9_x1b, r9_x2s;
    logic [27:0] r9_temp;
    logic [31:0] pf;
    assign pf = r9_p + asr(r9_x1b + r9_x2s + K_3791, 4);

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
            r9_v <= 1'b0; o_strobe <= 1'b0;
        end else begin
            r1_v <= d1_vld; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v;   r6_v <= r5_v; r7_v <= r6_v; r8_v <= d2_vld;
            r9_v <= r8_v;   o_strobe <= r9_v;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r1_tz   <= d1_tz;
        r1_b6   <= b5 - B6_OFFSET;
        r1_temp <= b5r[27:0];
        r1_up   <= d1_up;

        r2_tz   <= r1_tz;
        r2_sqp  <= r1_b6 * r1_b6;
        r2_ac2p <= sx16(i_cal.ac2) * r1_b6;
        r2_ac3p <= sx16(i_cal.ac3) * r1_b6;
        r2_temp <= r1_temp;
        r2_up   <= r1_up;

        r3_tz   <= r2_tz;
        r3_sq   <= asr(r2_sqp, 12);
        r3_x2a  <= asr(r2_ac2p, 11);
        r3_x1c  <= asr(r2_ac3p, 13);
        r3_temp <= r2_temp;
        r3_up   <= r2_up;

        r4_tz   <= r3_tz;
        r4_b2sq <= sx16(i_cal.b2) * r3_sq;
        r4_b1sq <= sx16(i_cal.b1) * r3_sq;
        r4_x2a  <= r3_x2a;
        r4_x1c  <= r3_x1c;
        r4_temp <= r3_temp;
        r4_up   <= r3_up;

        r5_tz   <= r4_tz;
        // Division by four that truncates toward zero.
        r5_b3   <= t3[31] ? asr(t3 + 32'd3, 2) : asr(t3, 2);
        r5_x3b  <= x3b;
        r5_temp <= r4_temp;
        r5_up   <= r4_up;

        r6_tz   <= r5_tz;
        r6_b4   <= b4;
        r6_b7p  <= {8'd0, r5_up} - r5_b3;
        r6_temp <= r5_temp;

        r7_tz   <= r6_tz;
        r7_b4   <= r6_b4;
        r7_b7   <= r6_b7p * (K_50000 >> i_cal.oss);
        r7_temp <= r6_temp;

        r8_tz   <= d2_tz;
        r8_bz   <= d2_bz;
        r8_p    <= p0;
        r8_x1m  <= ps * ps;
        r8_x2m  <= p0 * K_M7357;
        r8_temp <= d2_temp;

        r9_tz   <= r8_tz;
        r9_bz   <= r8_bz;
        r9_p    <= r8_p;
        r9_x1b  <= asr(r8_x1m * K_3038, 16);
        r9_x2s  <= asr(r8_x2m, 16);
        r9_temp <= r8_temp;

        // Result beat with error handling.
        priority if (r9_tz) begin
            o_result.pressure_pa        <= '0;
            o_result.temperature_tenths <= '0;
            o_result.error_status       <= ERR_TEMP_DIV0;
        end else if (r9_bz) begin
            o_result.pressure_pa        <= '0;
            o_result.temperature_tenths <= r9_temp;
            o_result.error_status       <= ERR_PRES_DIV0;
        end else begin
            o_result.pressure_pa        <= pf;
            o_result.temperature_tenths <= r9_temp;
            o_result.error_status       <= ERR_OK;
        end
    end
endmodule
`default_nettype wire

### rtl/core/barometric_pressure_compensation.sv
// Top level of the barometric pressure and temperature compensation block.
// Depends on bpc_pkg, bpc_front, bpc_fifo, bpc_back and assert_macros.svh.
//
// Usage:
// - Load the calibration words and the oversampling mode through the write
//   port (i_cfg_we, i_cfg_idx, i_cfg_wdata) while no beat is in flight.
//   Writes to indexes past the oversampling mode are ignored.
// - Present a raw temperature and pressure beat on i_item with i_start; it
//   is taken on any edge where i_start is high and o_busy is low.
// - Each beat yields one result on o_result, marked by o_strobe for a
//   single cycle. The receiver cannot hold results off.
// - From acceptance to strobe a beat passes three front stages, the
//   queue, and a back part set by two 32-stage bit-per-stage dividers.
// - Throughput is one beat per cycle; the dividers and the polynomial
//   stages are fully pipelined, and the queue drains every cycle.
// - Reset clears the calibration registers, the queue and every valid bit;
//   no strobe is raised until a new beat has passed through.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_in         i_item,
    output logic             o_busy,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_strobe,
    output t_out             o_result
);
    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;
    t_cal        cal;
    logic        accept;
    logic        q_push, q_valid, q_afull;
    t_fq         q_in, q_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_wdata;
                CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_wdata;
                CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_wdata;
                CFG_B1_B2:   r_b1_b2   <= i_cfg_wdata;
                CFG_MC_MD:   r_mc_md   <= i_cfg_wdata;
                CFG_OSS:     r_oss     <= i_cfg_wdata[1:0];
                default:     ;
            endcase
        end
    end

    // Split the words into coefficients.
    assign cal = '{ac1: r_ac1_ac2[31:16], ac2: r_ac1_ac2[15:0],
                   ac3: r_ac3_ac4[31:16], ac4: r_ac3_ac4[15:0],
                   ac5: r_ac5_ac6[31:16], ac6: r_ac5_ac6[15:0],
                   b1:  r_b1_b2[31:16],   b2:  r_b1_b2[15:0],
                   mc:  r_mc_md[31:16],   md:  r_mc_md[15:0],
                   oss: r_oss};

    assign accept = i_start && !o_busy;
    assign o_busy = q_afull;

    bpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cal    (cal),
        .o_push   (q_push),
        .o_data   (q_in)
    );

    bpc_fifo u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_push),
        .i_data        (q_in),
        .o_valid       (q_valid),
        .o_data        (q_out),
        .o_almost_full (q_afull)
    );

    bpc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_out),
        .i_cal    (cal),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // The queue drains every cycle, so the front is never held off.
    `BPC_ASSERT(a_never_busy, !o_busy)
    // A temperature fault clears both values.
    `BPC_ASSERT(a_temp_fault, !(o_strobe && o_result.error_status == ERR_TEMP_DIV0) || (o_result.pressure_pa == 0 && o_result.temperature_tenths == 0))
    // No status code beyond the pressure fault is produced.
    `BPC_ASSERT(a_status_code, !o_strobe || o_result.error_status != 2'd3)
    // The oversampling write lands in its register.
    `BPC_ASSERT_NEXT(a_oss_write, i_cfg_we && i_cfg_idx == CFG_OSS, r_oss == $past(i_cfg_wdata[1:0]))
endmodule
`default_nettype wire
